// ----- rtl/core/mrr_pkg.sv -----
// Shared types, codes and helper functions for the Modbus RTU response receiver.
// Used by mrr_frame and modbus_rtu_response_receiver; depends on nothing else.
package mrr_pkg;

  // Operation codes carried on the input channel.
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // Final status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SLAVE   = 3'd1;
  localparam logic [2:0] ST_CRC     = 3'd2;
  localparam logic [2:0] ST_LEN     = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  // CRC-16 constants (reflected polynomial, low byte sent first).
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Function code bit that marks an exception response.
  localparam logic [7:0] FC_EXCEPTION = 8'h80;

  // Receiver phase.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1
  } mrr_phase_t;

  // One input beat.
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } mrr_in_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] pdu_byte;
    logic       pdu_byte_valid;
    logic       frame_done;
    logic [2:0] status;
    logic [7:0] pdu_length;
  } mrr_out_t;

  // Result handed from the frame tracker to the output register.
  typedef struct packed {
    logic     valid;
    mrr_out_t data;
  } mrr_res_t;

  // Feeds one byte into the running CRC, one bit per step.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // PDU length from function code and byte count; zero marks an unknown code.
  function automatic logic [8:0] decode_len(input logic [7:0] fc, input logic [7:0] count);
    logic [8:0] len;
    if ((fc & FC_EXCEPTION) != 8'h00) begin
      len = 9'd2;
    end else begin
      case (fc) inside
        8'h01, 8'h02, 8'h03, 8'h04, 8'h0C, 8'h14, 8'h15, 8'h17, 8'h18:
          len = 9'd2 + {1'b0, count};
        8'h05, 8'h06, 8'h08, 8'h0B, 8'h0F, 8'h10, 8'h11:
          len = 9'd5;
        8'h07:
          len = 9'd2;
        8'h16:
          len = 9'd7;
        default:
          len = 9'd0;
      endcase
    end
    return len;
  endfunction

endpackage

// ----- rtl/core/mrr_frame.sv -----
// Frame tracker: holds the per-response state and works out the result of one beat.
// Depends on mrr_pkg.
module mrr_frame #(
  parameter int MAX_ADU_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  mrr_pkg::mrr_in_t  item,
  input  logic [7:0]        expected_slave_id,
  output mrr_pkg::mrr_res_t res
);
  import mrr_pkg::*;

  localparam logic [8:0] LenLimit = 9'(MAX_ADU_BYTES - 3);

  mrr_phase_t  phase, phase_next;
  logic [8:0]  byte_position, byte_position_next;
  logic [8:0]  frame_length, frame_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic [7:0]  function_byte, function_byte_next;
  logic        slave_matched, slave_matched_next;

  logic [15:0] crc_fed;
  logic [8:0]  len;
  logic [9:0]  pos_ahead;
  logic [8:0]  pos_inc;
  logic [8:0]  pdu_len_full;

  // Shared datapath pieces for the current byte.
  assign crc_fed      = crc_feed(running_crc, item.rx_byte);
  assign len          = decode_len(function_byte, item.rx_byte);
  assign pos_ahead    = {1'b0, byte_position} + 10'd2;
  assign pos_inc      = byte_position + 9'd1;
  assign pdu_len_full = frame_length - 9'd3;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_position <= '0;
      frame_length  <= '0;
      running_crc   <= CRC_INIT;
      crc_low_byte  <= '0;
      function_byte <= '0;
      slave_matched <= 1'b0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      frame_length  <= frame_length_next;
      running_crc   <= running_crc_next;
      crc_low_byte  <= crc_low_byte_next;
      function_byte <= function_byte_next;
      slave_matched <= slave_matched_next;
    end
  end

  // Next state and result of the beat being processed.
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    frame_length_next  = frame_length;
    running_crc_next   = running_crc;
    crc_low_byte_next  = crc_low_byte;
    function_byte_next = function_byte;
    slave_matched_next = slave_matched;
    res                = '0;

    if (go) begin
      case (item.operation)
        OP_START: begin
          phase_next         = PH_RECV;
          byte_position_next = '0;
          frame_length_next  = '0;
          running_crc_next   = CRC_INIT;
          crc_low_byte_next  = '0;
          function_byte_next = '0;
          slave_matched_next = 1'b0;
        end
        OP_TIMEOUT: begin
          if (phase == PH_RECV) begin
            phase_next           = PH_IDLE;
            res.valid            = 1'b1;
            res.data.frame_done  = 1'b1;
            res.data.status      = ST_TIMEOUT;
          end
        end
        OP_BYTE: begin
          if (phase == PH_RECV) begin
            if (byte_position == 9'd0) begin
              // Slave address byte: no result.
              slave_matched_next = (item.rx_byte == expected_slave_id);
              running_crc_next   = crc_fed;
              byte_position_next = 9'd1;
            end else if (byte_position == 9'd1) begin
              // Function code byte.
              function_byte_next      = item.rx_byte;
              running_crc_next        = crc_fed;
              byte_position_next      = 9'd2;
              res.valid               = 1'b1;
              res.data.pdu_byte       = item.rx_byte;
              res.data.pdu_byte_valid = 1'b1;
            end else if (byte_position == 9'd2) begin
              // Third byte settles the frame length or ends the frame.
              if (len == 9'd0 || len > LenLimit) begin
                phase_next          = PH_IDLE;
                res.valid           = 1'b1;
                res.data.frame_done = 1'b1;
                res.data.status     = ST_LEN;
              end else begin
                frame_length_next       = len + 9'd3;
                running_crc_next        = crc_fed;
                byte_position_next      = 9'd3;
                res.valid               = 1'b1;
                res.data.pdu_byte       = item.rx_byte;
                res.data.pdu_byte_valid = 1'b1;
              end
            end else if (pos_ahead < {1'b0, frame_length}) begin
              // Body of the PDU.
              running_crc_next        = crc_fed;
              byte_position_next      = pos_inc;
              res.valid               = 1'b1;
              res.data.pdu_byte       = item.rx_byte;
              res.data.pdu_byte_valid = 1'b1;
            end else if (pos_ahead == {1'b0, frame_length}) begin
              // Low CRC byte is held for the final compare.
              crc_low_byte_next  = item.rx_byte;
              byte_position_next = pos_inc;
            end else begin
              // High CRC byte: report the final status.
              phase_next          = PH_IDLE;
              byte_position_next  = pos_inc;
              res.valid           = 1'b1;
              res.data.frame_done = 1'b1;
              if (!slave_matched) begin
                res.data.status = ST_SLAVE;
              end else if ({item.rx_byte, crc_low_byte} != running_crc) begin
                res.data.status = ST_CRC;
              end else begin
                res.data.status     = ST_OK;
                res.data.pdu_length = pdu_len_full[7:0];
              end
            end
          end
        end
        default: begin
          // Unused operation code: ignored.
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/modbus_rtu_response_receiver.sv -----
// Modbus RTU response receiver top level: input register, frame tracker and result register.
// Depends on mrr_pkg and mrr_frame.
//
// Usage: each input beat carries an operation (received byte, start of a new
// response, or receive timeout) and the byte itself. Beats are taken on the
// in channel with valid and ready; results leave on the out channel the same
// way. A beat gives at most one result: a tentative PDU byte as it arrives,
// or a final beat with frame_done set and the status (ok, wrong slave, CRC
// mismatch, bad length or function, timeout) and, when ok, the PDU length.
// The slave address and low CRC bytes give no result.
// An accepted beat passes the input register, then the result register, before
// its result leaves. One beat is accepted every cycle while the out side does
// not stall, as the CRC update and length decode behind the input register are
// combinational. When the out side stalls, the result register and then the
// input register fill, and in_ready drops until the out side takes a beat. The
// user must write the slave address register through cfg_we and cfg_wdata while
// the block is idle; the block does not enforce it. Synchronous reset empties
// both registers, zeroes the slave address and leaves the receiver awaiting a start.
module modbus_rtu_response_receiver #(
  parameter int MAX_ADU_BYTES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mrr_pkg::mrr_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output mrr_pkg::mrr_out_t out_data,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata
);
  import mrr_pkg::*;

  logic      in_full;
  mrr_in_t   in_q;
  logic      go;
  mrr_res_t  res;
  logic      out_full;
  mrr_out_t  out_q;
  logic [7:0] expected_slave_id;

  // A held beat is processed when the result register can take its result.
  assign go        = in_full && (!out_full || out_ready);
  assign in_ready  = !in_full || go;
  assign out_valid = out_full;
  assign out_data  = out_q;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_slave_id <= '0;
    end else if (cfg_we) begin
      expected_slave_id <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  // Frame tracking and result decode.
  mrr_frame #(
    .MAX_ADU_BYTES(MAX_ADU_BYTES)
  ) u_frame (
    .clk              (clk),
    .rst              (rst),
    .go               (go),
    .item             (in_q),
    .expected_slave_id(expected_slave_id),
    .res              (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (go) begin
      out_full <= res.valid;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res.valid) begin
      out_q <= res.data;
    end
  end

endmodule
